/* hdl/ekd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped key decoder package
// Shared constants and the result type passed from the parser to the output
// register.
// ----------------------------------------------------------------------------
package ekd_pkg;

  // Longest key in bytes that the decoder will emit.
  localparam logic [7:0] MAX_KEY_LEN = 8'd250;

  // End-of-string status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_BADHEX  = 3'd2;
  localparam logic [2:0] ST_CUTOFF  = 3'd3;
  localparam logic [2:0] ST_TOOLONG = 3'd4;

  // One result item.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] key_byte;
    logic       end_of_key;
    logic [2:0] status;
    logic       min_key;
  } ekd_result_t;

endpackage

/* hdl/ekd_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped key parser
// Holds the per-string parse state and decodes one character per transfer
// into an optional key byte and the end-of-string report.
// ----------------------------------------------------------------------------
module ekd_parse
  import ekd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,       // commit the current character
  input  logic [7:0]  ch,
  input  logic        is_last,
  input  logic        is_empty,
  output logic        res_valid,  // the current character yields a result
  output ekd_result_t res
);

  // Parse mode codes.
  localparam logic [3:0] MODE_START = 4'd0;
  localparam logic [3:0] MODE_BODY  = 4'd1;
  localparam logic [3:0] MODE_ESC1  = 4'd2;
  localparam logic [3:0] MODE_ESC2  = 4'd3;
  localparam logic [3:0] MODE_DASH  = 4'd4;
  localparam logic [3:0] MODE_DI    = 4'd5;
  localparam logic [3:0] MODE_DIN   = 4'd6;
  localparam logic [3:0] MODE_DINF  = 4'd7;

  logic [3:0] mode_r, mode_nxt;
  logic [3:0] high_r, high_nxt;
  logic [7:0] count_r, count_nxt;
  logic [2:0] err_r, err_nxt;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_word;
  logic [7:0] lower;

  // Character classes.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex_val = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      hex_val = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      hex_val = 4'(ch - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_word = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) ||
                   (ch >= 8'h30 && ch <= 8'h39) || (ch == 8'h5f);
  assign lower   = ch | 8'h20;

  // Next state and result for the current character.
  always_comb begin
    logic       have;
    logic [7:0] kb;
    logic       bv;
    logic       done;
    have      = 1'b0;
    kb        = 8'd0;
    bv        = 1'b0;
    mode_nxt  = mode_r;
    high_nxt  = high_r;
    count_nxt = count_r;
    err_nxt   = err_r;

    if (!is_empty && err_r == ST_OK) begin
      case (mode_r)
        MODE_START, MODE_BODY: begin
          if (mode_r == MODE_START && ch == 8'h2d) begin
            mode_nxt = MODE_DASH;
          end else if (ch == 8'h5c) begin
            mode_nxt = MODE_ESC1;
          end else if (is_word) begin
            mode_nxt = MODE_BODY;
            kb       = ch;
            have     = 1'b1;
          end else begin
            err_nxt = ST_ILLEGAL;
          end
        end
        MODE_ESC1: begin
          if (is_hex) begin
            high_nxt = hex_val;
            mode_nxt = MODE_ESC2;
          end else begin
            err_nxt = ST_BADHEX;
          end
        end
        MODE_ESC2: begin
          if (is_hex) begin
            kb       = {high_r, hex_val};
            have     = 1'b1;
            mode_nxt = MODE_BODY;
          end else begin
            err_nxt = ST_BADHEX;
          end
        end
        MODE_DASH: begin
          if (lower == 8'h69) mode_nxt = MODE_DI;
          else err_nxt = ST_ILLEGAL;
        end
        MODE_DI: begin
          if (lower == 8'h6e) mode_nxt = MODE_DIN;
          else err_nxt = ST_ILLEGAL;
        end
        MODE_DIN: begin
          if (lower == 8'h66) mode_nxt = MODE_DINF;
          else err_nxt = ST_ILLEGAL;
        end
        default: begin
          err_nxt = ST_ILLEGAL;
        end
      endcase

      // Length check on an emitted byte.
      if (have) begin
        if (count_r < MAX_KEY_LEN) begin
          bv        = 1'b1;
          count_nxt = count_r + 8'd1;
        end else begin
          err_nxt = ST_TOOLONG;
          kb      = 8'd0;
        end
      end
    end

    done = is_empty || is_last;

    res            = '0;
    res.byte_valid = bv;
    res.key_byte   = kb;
    res.end_of_key = done;
    if (done) begin
      if (err_nxt != ST_OK) begin
        res.status = err_nxt;
      end else if (mode_nxt == MODE_ESC1 || mode_nxt == MODE_ESC2) begin
        res.status = ST_CUTOFF;
      end else if (mode_nxt == MODE_DASH || mode_nxt == MODE_DI ||
                   mode_nxt == MODE_DIN) begin
        res.status = ST_ILLEGAL;
      end else begin
        res.status  = ST_OK;
        res.min_key = (mode_nxt == MODE_DINF);
      end
      // A finished string returns everything to the start of string.
      mode_nxt  = MODE_START;
      high_nxt  = 4'd0;
      count_nxt = 8'd0;
      err_nxt   = ST_OK;
    end

    res_valid = done || bv;
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      high_r  <= 4'd0;
      count_r <= 8'd0;
      err_r   <= ST_OK;
    end else if (step) begin
      mode_r  <= mode_nxt;
      high_r  <= high_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* hdl/ekd_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped key output register
// Holds one result until the downstream side takes it, and takes a new one
// in the same cycle that the held result leaves.
// ----------------------------------------------------------------------------
module ekd_out_reg
  import ekd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_valid,
  input  ekd_result_t load_res,
  output logic        load_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output ekd_result_t out_res
);

  logic        valid_r;
  ekd_result_t res_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

/* hdl/escaped_key_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped key decoder core
// A character taken into the input register is decoded there, and its result
// is loaded into the output register and transfers from it; one character
// per cycle is accepted when results are taken without stall. Characters
// that give no result never wait on the output side. Synchronous active-low
// reset clears the parse state and both valid flags; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module escaped_key_decoder_core
  import ekd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // is_last
  input  logic        in_tuser,   // is_empty
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] key_byte, [10:8] status, [15:11] zero
  output logic        out_tlast,  // end_of_key
  output logic [1:0]  out_tuser   // [0] byte_valid, [1] min_key
);

  logic        in_valid_r;
  logic [7:0]  ch_r;
  logic        last_r;
  logic        empty_r;

  logic        res_valid;
  ekd_result_t res;
  logic        load_ready;
  logic        advance;
  ekd_result_t out_res;

  // A held character moves on when it yields nothing or the output can take it.
  assign advance   = in_valid_r && (!res_valid || load_ready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r    <= in_tdata;
      last_r  <= in_tlast;
      empty_r <= in_tuser;
    end
  end

  ekd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .ch        (ch_r),
    .is_last   (last_r),
    .is_empty  (empty_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ekd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid_r && res_valid),
    .load_res   (res),
    .load_ready (load_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Result transfer packing.
  assign out_tdata = {5'd0, out_res.status, out_res.key_byte};
  assign out_tlast = out_res.end_of_key;
  assign out_tuser = {out_res.min_key, out_res.byte_valid};

endmodule
